// ----- hw/rtl/pbb_pkg.sv -----
// Shared types, widths and register codes for the pixel block binning design.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package pbb_pkg;

    localparam int SUM_W      = 40;
    localparam int PIX_W      = 32;
    localparam int DIM_W      = 16;
    localparam int BIN_W      = 5;
    localparam int AREA_W     = 9;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = 5;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 3'd5;

    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;

    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [DIM_W-1:0]     dim_t;
    typedef logic [BIN_W-1:0]     bin_t;
    typedef logic [AREA_W-1:0]    area_t;
    typedef logic [Q_CNT_W-1:0]   qcnt_t;
    typedef logic [Q_PTR_W-1:0]   qptr_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [DIV_CNT_W-1:0] divcnt_t;

    // Clamped and derived configuration, valid while settled is high
    typedef struct packed {
        logic       settled;
        bin_t       bx;
        bin_t       by;
        dim_t       w;
        dim_t       h;
        dim_t       nw;
        dim_t       used_w;
        dim_t       used_h;
        area_t      area;
        logic [1:0] depth;
        logic       avg;
    } cfg_t;

    // One finished block sum waiting for the back end
    typedef struct packed {
        sum_t sum;
        logic row_end;
        logic frame_end;
    } blk_t;

    function automatic pix_t pix_mask(input logic [1:0] depth);
        pix_t m;
        case (depth)
            DEPTH_8:  m = 32'h0000_00FF;
            DEPTH_16: m = 32'h0000_FFFF;
            default:  m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic pix_t sat_value(input sum_t v, input logic [1:0] depth);
        sum_t lim;
        lim = sum_t'(pix_mask(depth));
        return (v > lim) ? pix_t'(lim) : pix_t'(v);
    endfunction

endpackage

// ----- hw/rtl/pbb_cfg.sv -----
// Configuration registers, clamping and derived block counts.
// Depends on pbb_pkg; the quotients come from a shared bit-serial sequence.
`timescale 1ns / 1ps

module pbb_cfg #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BIN   = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pbb_pkg::cfg_t                   cfg
);

    localparam pbb_pkg::step_t STEP_LAST = pbb_pkg::step_t'(pbb_pkg::DIV_STEPS + 1);

    logic [3:0]  bin_x_reg;
    logic [3:0]  bin_y_reg;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [1:0]  depth_reg;
    logic        avg_reg;
    logic        busy_reg;
    pbb_pkg::step_t step_reg;

    pbb_pkg::dim_t  wdiv_reg;
    pbb_pkg::dim_t  hdiv_reg;
    pbb_pkg::bin_t  wrem_reg;
    pbb_pkg::bin_t  hrem_reg;
    pbb_pkg::dim_t  used_w_reg;
    pbb_pkg::dim_t  used_h_reg;
    pbb_pkg::area_t area_reg;

    pbb_pkg::bin_t bx_c;
    pbb_pkg::bin_t by_c;
    pbb_pkg::dim_t w_c;
    pbb_pkg::dim_t h_c;

    logic [pbb_pkg::BIN_W:0] wrem_sh;
    logic [pbb_pkg::BIN_W:0] hrem_sh;
    logic                    wge;
    logic                    hge;
    logic                    wr_acc;

    assign cfg_ready = 1'b1;
    assign wr_acc    = cfg_valid && cfg_ready;

    always_comb
    begin
        if (bin_x_reg == 4'd0)
            bx_c = pbb_pkg::bin_t'(1);
        else if (pbb_pkg::bin_t'(bin_x_reg) > pbb_pkg::bin_t'(MAX_BIN))
            bx_c = pbb_pkg::bin_t'(MAX_BIN);
        else
            bx_c = pbb_pkg::bin_t'(bin_x_reg);

        if (bin_y_reg == 4'd0)
            by_c = pbb_pkg::bin_t'(1);
        else if (pbb_pkg::bin_t'(bin_y_reg) > pbb_pkg::bin_t'(MAX_BIN))
            by_c = pbb_pkg::bin_t'(MAX_BIN);
        else
            by_c = pbb_pkg::bin_t'(bin_y_reg);

        if (width_reg == 13'd0)
            w_c = pbb_pkg::dim_t'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_c = pbb_pkg::dim_t'(MAX_WIDTH);
        else
            w_c = pbb_pkg::dim_t'(width_reg);

        h_c = (height_reg == 16'd0) ? pbb_pkg::dim_t'(1) : height_reg;
    end

    // Restoring division: the quotient shifts into the dividend register
    assign wrem_sh = {wrem_reg, wdiv_reg[pbb_pkg::DIM_W-1]};
    assign hrem_sh = {hrem_reg, hdiv_reg[pbb_pkg::DIM_W-1]};
    assign wge     = wrem_sh >= {1'b0, bx_c};
    assign hge     = hrem_sh >= {1'b0, by_c};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_x_reg  <= 4'd1;
            bin_y_reg  <= 4'd1;
            width_reg  <= 13'd4096;
            height_reg <= 16'd4096;
            depth_reg  <= pbb_pkg::DEPTH_16;
            avg_reg    <= 1'b0;
            busy_reg   <= 1'b1;
            step_reg   <= '0;
        end
        else
        begin
            if (wr_acc)
            begin
                case (cfg_index)
                    pbb_pkg::REG_BIN_X:        bin_x_reg  <= cfg_data[3:0];
                    pbb_pkg::REG_BIN_Y:        bin_y_reg  <= cfg_data[3:0];
                    pbb_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[12:0];
                    pbb_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    pbb_pkg::REG_PIXEL_DEPTH:  depth_reg  <= cfg_data[1:0];
                    pbb_pkg::REG_AVERAGE_MODE: avg_reg    <= cfg_data[0];
                    default: ;
                endcase
                // restart the derive sequence on any write
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_LAST)
                    busy_reg <= 1'b0;
                else
                    step_reg <= step_reg + pbb_pkg::step_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !wr_acc)
        begin
            if (step_reg == '0)
            begin
                wdiv_reg <= w_c;
                hdiv_reg <= h_c;
                wrem_reg <= '0;
                hrem_reg <= '0;
            end
            else if (step_reg == STEP_LAST)
            begin
                used_w_reg <= pbb_pkg::dim_t'(wdiv_reg * bx_c);
                used_h_reg <= pbb_pkg::dim_t'(hdiv_reg * by_c);
                area_reg   <= pbb_pkg::area_t'(bx_c * by_c);
            end
            else
            begin
                wdiv_reg <= {wdiv_reg[pbb_pkg::DIM_W-2:0], wge};
                hdiv_reg <= {hdiv_reg[pbb_pkg::DIM_W-2:0], hge};
                wrem_reg <= wge ? pbb_pkg::bin_t'(wrem_sh - {1'b0, bx_c})
                                : wrem_sh[pbb_pkg::BIN_W-1:0];
                hrem_reg <= hge ? pbb_pkg::bin_t'(hrem_sh - {1'b0, by_c})
                                : hrem_sh[pbb_pkg::BIN_W-1:0];
            end
        end
    end

    assign cfg.settled = !busy_reg;
    assign cfg.bx      = bx_c;
    assign cfg.by      = by_c;
    assign cfg.w       = w_c;
    assign cfg.h       = h_c;
    assign cfg.nw      = wdiv_reg;
    assign cfg.used_w  = used_w_reg;
    assign cfg.used_h  = used_h_reg;
    assign cfg.area    = area_reg;
    assign cfg.depth   = depth_reg;
    assign cfg.avg     = avg_reg;

    a_write_unsettles: assert property (@(posedge clk) disable iff (!rst_n)
        wr_acc |=> !cfg.settled)
        else $error("config write did not restart the derive sequence");

endmodule

// ----- hw/rtl/pbb_front.sv -----
// Front end: raster counters, row running sum and the column sum line store.
// Depends on pbb_pkg; pushes finished block sums into the queue.
`timescale 1ns / 1ps

module pbb_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BIN   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pbb_pkg::cfg_t  cfg,
    input  logic           pix_valid,
    output logic           pix_ready,
    input  pbb_pkg::pix_t  pixel,
    input  pbb_pkg::qcnt_t q_count,
    output logic           q_push,
    output pbb_pkg::blk_t  q_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int BCW = $clog2(MAX_BIN);

    logic [CW-1:0]  cp_reg, cp_next;
    logic [CW-1:0]  oc_reg, oc_next;
    logic [BCW-1:0] wbc_reg, wbc_next;
    logic [BCW-1:0] wbr_reg, wbr_next;
    pbb_pkg::dim_t  rp_reg, rp_next;
    pbb_pkg::sum_t  rr_reg, rr_next;

    // second stage: one block column closing
    logic           b_valid_reg;
    logic [CW-1:0]  b_idx_reg;
    logic           b_first_reg;
    logic           b_final_reg;
    logic           b_rend_reg;
    logic           b_fend_reg;
    pbb_pkg::sum_t  b_rsum_reg;

    pbb_pkg::sum_t  mem [MAX_WIDTH];
    pbb_pkg::sum_t  mem_q_reg;
    pbb_pkg::sum_t  fwd_data_reg;
    logic           fwd_reg;

    logic           acc;
    logic           in_rows;
    logic           active;
    logic           blk_done;
    logic           blk_final;
    logic           row_done;
    logic           frame_wrap;
    logic           rend;
    logic           fend;
    logic           rd_en;
    logic           fwd_hit;
    pbb_pkg::sum_t  pix_ext;
    pbb_pkg::sum_t  rsum;
    pbb_pkg::sum_t  rd_data;
    pbb_pkg::sum_t  col_b;

    // two free slots cover the item in the second stage
    assign pix_ready = cfg.settled && (q_count <= pbb_pkg::qcnt_t'(pbb_pkg::Q_DEPTH - 2));
    assign acc       = pix_valid && pix_ready;

    assign in_rows    = rp_reg < cfg.used_h;
    assign active     = (pbb_pkg::dim_t'(cp_reg) < cfg.used_w) && in_rows;
    assign pix_ext    = pbb_pkg::sum_t'(pixel & pbb_pkg::pix_mask(cfg.depth));
    assign rsum       = rr_reg + pix_ext;
    assign blk_done   = active && (pbb_pkg::bin_t'(wbc_reg) + pbb_pkg::bin_t'(1) >= cfg.bx);
    assign blk_final  = pbb_pkg::bin_t'(wbr_reg) + pbb_pkg::bin_t'(1) >= cfg.by;
    assign row_done   = pbb_pkg::dim_t'(cp_reg) + pbb_pkg::dim_t'(1) >= cfg.w;
    assign frame_wrap = {1'b0, rp_reg} + 17'd1 >= {1'b0, cfg.h};
    assign rend       = pbb_pkg::dim_t'(oc_reg) + pbb_pkg::dim_t'(1) >= cfg.nw;
    assign fend       = rend && ({1'b0, rp_reg} + 17'd1 >= {1'b0, cfg.used_h});
    assign rd_en      = acc && blk_done;

    always_comb
    begin
        cp_next  = cp_reg;
        oc_next  = oc_reg;
        wbc_next = wbc_reg;
        wbr_next = wbr_reg;
        rp_next  = rp_reg;
        rr_next  = rr_reg;
        if (acc)
        begin
            if (active)
            begin
                if (blk_done)
                begin
                    rr_next  = '0;
                    wbc_next = '0;
                    oc_next  = oc_reg + CW'(1);
                end
                else
                begin
                    rr_next  = rsum;
                    wbc_next = wbc_reg + BCW'(1);
                end
            end
            if (row_done)
            begin
                cp_next  = '0;
                wbc_next = '0;
                rr_next  = '0;
                oc_next  = '0;
                if (in_rows)
                    wbr_next = blk_final ? '0 : wbr_reg + BCW'(1);
                if (frame_wrap)
                begin
                    rp_next  = '0;
                    wbr_next = '0;
                end
                else
                    rp_next = rp_reg + pbb_pkg::dim_t'(1);
            end
            else
                cp_next = cp_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg      <= '0;
            oc_reg      <= '0;
            wbc_reg     <= '0;
            wbr_reg     <= '0;
            rp_reg      <= '0;
            rr_reg      <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            cp_reg      <= cp_next;
            oc_reg      <= oc_next;
            wbc_reg     <= wbc_next;
            wbr_reg     <= wbr_next;
            rp_reg      <= rp_next;
            rr_reg      <= rr_next;
            b_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            b_idx_reg   <= oc_reg;
            b_first_reg <= (wbr_reg == '0);
            b_final_reg <= blk_final;
            b_rend_reg  <= rend;
            b_fend_reg  <= fend;
            b_rsum_reg  <= rsum;
        end
    end

    // line store: the second stage writes, the first stage reads
    always_ff @(posedge clk)
    begin
        if (b_valid_reg && !b_final_reg)
            mem[b_idx_reg] <= col_b;
        if (rd_en)
            mem_q_reg <= mem[oc_reg];
    end

    // bypass a write to the same column that lands in the read cycle
    assign fwd_hit = b_valid_reg && !b_final_reg && (b_idx_reg == oc_reg);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_reg      <= fwd_hit;
            fwd_data_reg <= col_b;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;
    assign col_b   = (b_first_reg ? '0 : rd_data) + b_rsum_reg;

    assign q_push           = b_valid_reg && b_final_reg;
    assign q_data.sum       = col_b;
    assign q_data.row_end   = b_rend_reg;
    assign q_data.frame_end = b_fend_reg;

    a_stage_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> $past(acc))
        else $error("second stage valid without an accepted beat");

    a_no_queue_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < pbb_pkg::qcnt_t'(pbb_pkg::Q_DEPTH)))
        else $error("block sum pushed into a full queue");

    a_column_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cp_reg) < MAX_WIDTH)
        else $error("column position ran past the line store");

endmodule

// ----- hw/rtl/pbb_fifo.sv -----
// Short queue of finished block sums between front and back end.
// Depends on pbb_pkg for the entry type and depth.
`timescale 1ns / 1ps

module pbb_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pbb_pkg::blk_t  push_data,
    input  logic           pop,
    output pbb_pkg::blk_t  head,
    output pbb_pkg::qcnt_t count
);

    pbb_pkg::blk_t  entry_reg [pbb_pkg::Q_DEPTH];
    pbb_pkg::qptr_t wr_ptr_reg;
    pbb_pkg::qptr_t rd_ptr_reg;
    pbb_pkg::qcnt_t count_reg;

    logic do_pop;
    logic do_push;

    assign do_pop  = pop && (count_reg != '0);
    assign do_push = push && ((count_reg != pbb_pkg::qcnt_t'(pbb_pkg::Q_DEPTH)) || do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + pbb_pkg::qptr_t'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + pbb_pkg::qptr_t'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + pbb_pkg::qcnt_t'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - pbb_pkg::qcnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ----- hw/rtl/pbb_back.sv -----
// Back end: optional division by block area, saturation and output register.
// Depends on pbb_pkg; takes block sums from the queue.
`timescale 1ns / 1ps

module pbb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pbb_pkg::cfg_t  cfg,
    input  pbb_pkg::qcnt_t q_count,
    input  pbb_pkg::blk_t  q_head,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output pbb_pkg::pix_t  out_value,
    output logic           out_last,
    output logic           out_user
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    pbb_pkg::sum_t    quot_reg, quot_next;
    pbb_pkg::area_t   rem_reg, rem_next;
    pbb_pkg::divcnt_t cnt_reg, cnt_next;
    logic             rend_reg, rend_next;
    logic             fend_reg, fend_next;

    logic             out_valid_reg, out_valid_next;
    pbb_pkg::pix_t    out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;
    logic             out_user_reg, out_user_next;

    logic                      q_nonempty;
    logic                      need_div;
    logic                      out_free;
    logic [pbb_pkg::AREA_W:0]  rem_sh;
    logic                      ge;

    assign q_nonempty = q_count != '0;
    assign need_div   = cfg.avg && (cfg.area != pbb_pkg::area_t'(1));
    assign out_free   = !out_valid_reg || out_ready;

    assign rem_sh = {rem_reg, quot_reg[pbb_pkg::SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, cfg.area};

    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        rend_next      = rend_reg;
        fend_next      = fend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        q_pop          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_nonempty)
                begin
                    if (need_div)
                    begin
                        q_pop      = 1'b1;
                        quot_next  = q_head.sum;
                        rem_next   = '0;
                        cnt_next   = pbb_pkg::divcnt_t'(pbb_pkg::SUM_W);
                        rend_next  = q_head.row_end;
                        fend_next  = q_head.frame_end;
                        state_next = S_DIV;
                    end
                    else if (out_free)
                    begin
                        // sum mode, or a block area of one, goes straight to the output register
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_value_next = pbb_pkg::sat_value(q_head.sum, cfg.depth);
                        out_last_next  = q_head.row_end;
                        out_user_next  = q_head.frame_end;
                    end
                end
            end
            S_DIV:
            begin
                quot_next = {quot_reg[pbb_pkg::SUM_W-2:0], ge};
                rem_next  = ge ? pbb_pkg::area_t'(rem_sh - {1'b0, cfg.area})
                               : rem_sh[pbb_pkg::AREA_W-1:0];
                cnt_next  = cnt_reg - pbb_pkg::divcnt_t'(1);
                if (cnt_reg == pbb_pkg::divcnt_t'(1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = pbb_pkg::sat_value(quot_reg, cfg.depth);
                    out_last_next  = rend_reg;
                    out_user_next  = fend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        rend_reg      <= rend_next;
        fend_reg      <= fend_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_user_reg  <= out_user_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;

    a_div_exits_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (state_reg == S_DIV || state_reg == S_DONE))
        else $error("divider left its sequence early");

endmodule

// ----- hw/rtl/pixel_block_binning.sv -----
// Channel        Dir  Payload (low bit first)                        Accept
// s_axis_*       in   tdata: pixel[31:0]                              tvalid & tready
// m_axis_*       out  tdata: binned_value[31:0]; tlast: row_end;      tvalid & tready
//                     tuser: frame_end
// cfg_*          in   cfg_index: register 0..5; cfg_data[15:0]        cfg_valid & cfg_ready
//
// The front end takes one pixel per cycle while the configuration is settled and the queue has room;
// with no division a block result passes the second stage, the queue and the output register.
// Average mode with a block area above one runs a radix-2 divider that takes one result at a time,
// so input stalls while three or more block sums wait in the four-entry queue.
// After reset and after every configuration write the derive sequence runs
// (bit-serial width and height division), during which no pixel is accepted.
// The line store has no reset; column sums are written before they are read.
`timescale 1ns / 1ps

module pixel_block_binning #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BIN   = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,   // pixel[31:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // binned_value[31:0]
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser,   // frame_end
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pbb_pkg::cfg_t  cfg;
    pbb_pkg::qcnt_t q_count;
    pbb_pkg::blk_t  q_data;
    pbb_pkg::blk_t  q_head;
    logic           q_push;
    logic           q_pop;

    pbb_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbb_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (s_axis_tvalid),
        .pix_ready (s_axis_tready),
        .pixel     (s_axis_tdata),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    pbb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .count     (q_count)
    );

    pbb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_count   (q_count),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for pixel_block_binning: streams raster pixels under many block
// geometries, depths and modes, predicts every binned beat and checks it.
// Depends on hw/rtl/pbb_pkg.sv and hw/rtl/pixel_block_binning.sv.
`timescale 1ns / 1ps

module tb_top;

    localparam int          MAX_WIDTH     = 4096;
    localparam int          MAX_BIN       = 8;
    localparam int          MAX_HEIGHT    = 65535;
    localparam int unsigned HOLD_CYCLES   = 64;
    localparam int unsigned CYCLE_LIMIT   = 3000000;
    localparam int unsigned RANDOM_PIXELS = 1100;

    localparam logic [1:0] DEPTH_32    = 2'd2;
    localparam logic [1:0] DEPTH_SPARE = 2'd3;

    localparam int unsigned DEPTH_8_CODE     = pbb_pkg::DEPTH_8;
    localparam int unsigned DEPTH_SPARE_CODE = DEPTH_SPARE;

    localparam logic [pbb_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [pbb_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        pbb_pkg::pix_t value;
        logic          row_end;
        logic          frame_end;
    } binned_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [pbb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pbb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Register copy, reset values
    logic [3:0]  cur_bin_x  = 4'd1;
    logic [3:0]  cur_bin_y  = 4'd1;
    logic [12:0] cur_width  = 13'd4096;
    logic [15:0] cur_height = 16'd4096;
    logic [1:0]  cur_depth  = pbb_pkg::DEPTH_16;
    logic        cur_avg    = 1'b0;

    // Binning state
    logic [39:0] line_sums [MAX_WIDTH];
    logic [39:0] run_sum = '0;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned blk_col = 0;
    int unsigned blk_row = 0;
    int unsigned out_col = 0;

    binned_t     binned_q [$];
    binned_t     head;
    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned stall_left  = 0;
    bit          steady      = 1'b0;

    pixel_block_binning DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int unsigned limit(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic pbb_pkg::pix_t rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return ($urandom & 32'hFFFF_FF00) | 32'h0000_00FF;
            3:       return ($urandom & 32'hFFFF_0000) | 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Fill the bits above the register width with noise now and then
    function automatic logic [15:0] cfg_word(input int unsigned value, input int unsigned bits,
                                             input bit junk);
        int unsigned keep;
        keep = (32'd1 << bits) - 1;
        if (junk && $urandom_range(0, 2) == 0)
            return 16'(($urandom & ~keep) | (value & keep));
        return 16'(value);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Advance the binning state by one pixel and queue the beat it completes
    task automatic bin_pixel(input pbb_pkg::pix_t value);
        int unsigned bx, by, w, h, nw, used_w, used_h;
        logic [39:0] mask, pix, col, v;
        logic        in_rows;
        binned_t     res;
        bx      = limit(32'(cur_bin_x), 1, MAX_BIN);
        by      = limit(32'(cur_bin_y), 1, MAX_BIN);
        w       = limit(32'(cur_width), 1, MAX_WIDTH);
        h       = limit(32'(cur_height), 1, MAX_HEIGHT);
        nw      = w / bx;
        used_w  = nw * bx;
        used_h  = (h / by) * by;
        in_rows = row_pos < used_h;
        case (cur_depth)
            pbb_pkg::DEPTH_8:  mask = 40'h00_0000_00FF;
            pbb_pkg::DEPTH_16: mask = 40'h00_0000_FFFF;
            default:           mask = 40'h00_FFFF_FFFF;
        endcase
        pix = 40'(value) & mask;
        if (col_pos < used_w && in_rows)
        begin
            run_sum = run_sum + pix;
            if (blk_col + 1 >= bx)
            begin
                col     = ((blk_row == 0) ? 40'h0 : line_sums[out_col]) + run_sum;
                run_sum = '0;
                blk_col = 0;
                if (blk_row + 1 >= by)
                begin
                    v = cur_avg ? col / (bx * by) : col;
                    if (v > mask)
                        v = mask;
                    res.value     = v[31:0];
                    res.row_end   = (out_col + 1 >= nw);
                    res.frame_end = res.row_end && (row_pos + 1 >= used_h);
                    binned_q.push_back(res);
                end
                else
                begin
                    line_sums[out_col] = col;
                end
                out_col = (out_col + 1) % MAX_WIDTH;
            end
            else
            begin
                blk_col = blk_col + 1;
            end
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            blk_col = 0;
            run_sum = '0;
            out_col = 0;
            if (in_rows)
                blk_row = (blk_row + 1 >= by) ? 0 : blk_row + 1;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
                blk_row = 0;
            end
        end
    endtask

    // Hold tvalid high across back-to-back beats; drop it only before a gap
    task automatic send_pixel(input pbb_pkg::pix_t value);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
        bin_pixel(value);
        pixels_sent++;
    endtask

    task automatic run_to_frame_end();
        do send_pixel(rand_pixel()); while (col_pos != 0 || row_pos != 0);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (binned_q.size() != 0) @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        case (idx)
            pbb_pkg::REG_BIN_X:        cur_bin_x  = value[3:0];
            pbb_pkg::REG_BIN_Y:        cur_bin_y  = value[3:0];
            pbb_pkg::REG_IMAGE_WIDTH:  cur_width  = value[12:0];
            pbb_pkg::REG_IMAGE_HEIGHT: cur_height = value[15:0];
            pbb_pkg::REG_PIXEL_DEPTH:  cur_depth  = value[1:0];
            pbb_pkg::REG_AVERAGE_MODE: cur_avg    = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned bx, input int unsigned by,
                              input int unsigned w, input int unsigned h,
                              input logic [1:0] depth, input logic avg, input bit junk);
        wait_idle();
        write_reg(pbb_pkg::REG_BIN_X, cfg_word(bx, 4, junk), 1'b0);
        write_reg(pbb_pkg::REG_BIN_Y, cfg_word(by, 4, junk), 1'b0);
        write_reg(pbb_pkg::REG_IMAGE_WIDTH, cfg_word(w, 13, junk), 1'b0);
        write_reg(pbb_pkg::REG_IMAGE_HEIGHT, cfg_word(h, 16, junk), 1'b0);
        write_reg(pbb_pkg::REG_PIXEL_DEPTH, cfg_word(32'(depth), 2, junk), 1'b0);
        write_reg(pbb_pkg::REG_AVERAGE_MODE, cfg_word(32'(avg), 1, junk), 1'b1);
    endtask

    function automatic int unsigned bin_code(input int unsigned b);
        if (b == 1 && $urandom_range(0, 7) == 0)
            return 0;
        if (b == MAX_BIN && $urandom_range(0, 1) == 0)
            return $urandom_range(MAX_BIN + 1, 15);
        return b;
    endfunction

    task automatic random_config();
        int unsigned bx, by, w, h;
        bx = $urandom_range(1, $urandom_range(1, MAX_BIN));
        by = $urandom_range(1, $urandom_range(1, MAX_BIN));
        if ($urandom_range(0, 15) == 0)
        begin
            w = $urandom_range(32, 120);
            h = by;
        end
        else
        begin
            // zero blocks across or down leaves only dropped pixels
            w = bx * $urandom_range(0, 3) + $urandom_range(0, bx - 1);
            h = by * $urandom_range(0, 2) + $urandom_range(0, by - 1);
        end
        set_config(bin_code(bx), bin_code(by), w, h,
                   2'($urandom_range(DEPTH_8_CODE, DEPTH_SPARE_CODE)),
                   1'($urandom_range(0, 1)), 1'b1);
    endtask

    // Reset geometry, then shrink the row while the column count sits past it
    task automatic test_reset_values();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'hFFFF_0000);
        send_pixel(32'h0001_8001);
        send_pixel($urandom);
        send_pixel($urandom);
        wait_idle();
        write_reg(pbb_pkg::REG_IMAGE_WIDTH, 16'd4, 1'b0);
        write_reg(pbb_pkg::REG_IMAGE_HEIGHT, 16'd2, 1'b1);
        run_to_frame_end();
    endtask

    task automatic test_depth_and_mode();
        logic [1:0] depths [4] = '{pbb_pkg::DEPTH_8, pbb_pkg::DEPTH_16, DEPTH_32, DEPTH_SPARE};
        int         d, a;
        for (d = 0; d < 4; d++)
        begin
            for (a = 0; a < 2; a++)
            begin
                set_config(2, 1, 2, 1, depths[d], a[0], 1'b0);
                send_pixel(32'hFFFF_FFFF);
                send_pixel(a[0] ? 32'hFFFF_FFFE : rand_pixel());
            end
        end
    endtask

    task automatic test_size_limits();
        // zero sizes act as one
        set_config(0, 0, 0, 0, pbb_pkg::DEPTH_8, 1'b1, 1'b0);
        send_pixel($urandom);
        set_config(0, 0, 3, 2, pbb_pkg::DEPTH_16, 1'b0, 1'b0);
        run_to_frame_end();
        // oversized width and block width, then cut the row short
        set_config(15, 1, 8191, 1, DEPTH_32, 1'b1, 1'b0);
        repeat (64) send_pixel(rand_pixel());
        wait_idle();
        write_reg(pbb_pkg::REG_IMAGE_WIDTH, 16'd64, 1'b1);
        run_to_frame_end();
        // block larger than the image yields nothing
        set_config(8, 9, 5, 3, pbb_pkg::DEPTH_16, 1'b0, 1'b0);
        repeat (15) send_pixel(rand_pixel());
        // tallest frame, cut short by a height write between rows
        set_config(1, 1, 2, MAX_HEIGHT, pbb_pkg::DEPTH_16, 1'b1, 1'b0);
        repeat (6) send_pixel(rand_pixel());
        wait_idle();
        write_reg(pbb_pkg::REG_IMAGE_HEIGHT, 16'd2, 1'b1);
        run_to_frame_end();
    endtask

    task automatic test_spare_registers();
        set_config(2, 2, 4, 4, pbb_pkg::DEPTH_8, 1'b1, 1'b0);
        @(posedge clk);
        write_reg(REG_SPARE_6, 16'hFFFF, 1'b0);
        write_reg(REG_SPARE_7, 16'h0001, 1'b1);
        run_to_frame_end();
    endtask

    task automatic test_random_frames();
        int unsigned goal, k, w_e, h_e;
        goal = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < goal)
        begin
            steady = ($urandom_range(0, 4) == 0);
            random_config();
            if ($urandom_range(0, 3) == 0)
            begin
                w_e = limit(32'(cur_width), 1, MAX_WIDTH);
                h_e = limit(32'(cur_height), 1, MAX_HEIGHT);
                k   = w_e * $urandom_range(0, h_e - 1);
                if ($urandom_range(0, 1) == 0)
                    k = k + $urandom_range(0, w_e - 1);
                repeat (k) send_pixel(rand_pixel());
                wait_idle();
                // new geometry only where a fresh block row starts
                if (col_pos == 0 && blk_row == 0)
                begin
                    random_config();
                end
                else
                begin
                    write_reg(pbb_pkg::REG_PIXEL_DEPTH,
                              cfg_word($urandom_range(DEPTH_8_CODE, DEPTH_SPARE_CODE), 2, 1'b1),
                              1'b0);
                    write_reg(pbb_pkg::REG_AVERAGE_MODE,
                              cfg_word($urandom_range(0, 1), 1, 1'b1), 1'b1);
                end
                run_to_frame_end();
            end
            repeat ($urandom_range(1, 2)) run_to_frame_end();
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (binned_q.size() == 0)
            begin
                report_mismatch($sformatf("beat with none expected, value %h", m_axis_tdata));
            end
            else
            begin
                head = binned_q.pop_front();
                if (m_axis_tdata !== head.value)
                    report_mismatch($sformatf("binned_value got %h want %h",
                                              m_axis_tdata, head.value));
                if (m_axis_tlast !== head.row_end)
                    report_mismatch($sformatf("row_end got %b want %b",
                                              m_axis_tlast, head.row_end));
                if (m_axis_tuser !== head.frame_end)
                    report_mismatch($sformatf("frame_end got %b want %b",
                                              m_axis_tuser, head.frame_end));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_depth_and_mode();
        test_size_limits();
        test_spare_registers();
        test_random_frames();
        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
